// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request and response
// words, operation codes and status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] NO_VALUE = -32'sd1;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [WORD_W-1:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       element_count;
    logic                     is_empty;
  } deq_rsp_t;

endpackage

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words in a circular slot memory.
// ----------------------------------------------------------------------------
// Each request word pushes, pops or peeks at either end and yields exactly one
// response word with the value read, a status, the element count after the
// request and an empty flag. Front/rear indices and the count update in the
// cycle a request is taken; the slot memory has a registered read, so the
// response is loaded into the output register in the cycle after the request
// is taken. No new request is taken while that response is pending or while
// the output register holds a stalled word; the response register holds while
// rsp_stall is high. A push on a full queue is refused with status full, a pop
// or peek on an empty queue returns -1 with status empty, and unused opcodes
// return -1 with status ok and change nothing.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  deq_pkg::deq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output deq_pkg::deq_rsp_t rsp
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [IW-1:0]       front, front_next;
  logic [IW-1:0]       rear, rear_next;
  logic [CW-1:0]       count, count_next;
  logic                pend;
  logic                pend_read;
  logic [STATUS_W-1:0] pend_status;

  logic [IW-1:0]       front_inc, front_dec, rear_inc, rear_dec;
  logic                acc, full, empty;
  logic                wr_en, rd_en, use_read;
  logic [IW-1:0]       wr_addr, rd_addr;
  logic [STATUS_W-1:0] status_next;
  logic [WORD_W-1:0]   rd_data;

  assign req_stall = pend || (rsp_valid && rsp_stall);
  assign acc       = req_valid && !req_stall;
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);

  assign front_inc = (front == LAST) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST : front - 1'b1;
  assign rear_inc  = (rear == LAST) ? '0 : rear + 1'b1;
  assign rear_dec  = (rear == '0) ? LAST : rear - 1'b1;

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = rear;
    rd_en       = 1'b0;
    rd_addr     = front;
    use_read    = 1'b0;
    status_next = ST_OK;
    unique case (req.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_next = front_dec;
          wr_en      = acc;
          wr_addr    = front_dec;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          rear_next  = rear_inc;
          wr_en      = acc;
          wr_addr    = rear;
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          front_next = front_inc;
          rd_en      = acc;
          rd_addr    = front;
          use_read   = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          rear_next  = rear_dec;
          rd_en      = acc;
          rd_addr    = rear_dec;
          use_read   = 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_en    = acc;
          rd_addr  = front;
          use_read = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_en    = acc;
          rd_addr  = rear_dec;
          use_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= acc;
      if (acc) begin
        front <= front_next;
        rear  <= rear_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_read   <= use_read;
      pend_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pend) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      rsp.read_value    <= pend_read ? $signed(rd_data) : NO_VALUE;
      rsp.status        <= pend_status;
      rsp.element_count <= COUNT_W'(count);
      rsp.is_empty      <= (count == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("element count above capacity");

  a_pend_slot_free: assert property (@(posedge clk) disable iff (rst)
    pend |-> !rsp_valid)
    else $error("read data arrives while output word still held");

  a_accept_pends: assert property (@(posedge clk) disable iff (rst)
    acc |=> pend)
    else $error("accepted word produced no pending response");

  a_index_count: assert property (@(posedge clk) disable iff (rst)
    (front == rear) == (count == '0 || count == DEPTH_C))
    else $error("indices disagree with element count");

endmodule

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Slot memory of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [deq_pkg::WORD_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [deq_pkg::WORD_W-1:0]  rd_data
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== bench/tb_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// Drives request words through the valid/stall channel in random bursts while
// the response side stalls on its own pattern. A shadow deque predicts every
// response word, and the checker compares each field in arrival order.
// Directed tests cover the empty queue, a full queue with refused pushes,
// corner data values and unused opcodes. Random traffic then alternates
// fill-heavy, drain-heavy and mixed phases so that both indices wrap and the
// queue hits full and empty many times.
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 380;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef enum int {STALL_NONE, STALL_SPOTTY, STALL_HEAVY} stall_mode_t;

  logic     clk;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  deq_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  deq_rsp_t rsp;

  // shadow deque
  logic signed [WORD_W-1:0] shadow_slots [DEPTH];
  int head_slot = 0;
  int tail_slot = 0;
  int held      = 0;

  deq_rsp_t pending_rsp [$];
  int       error_count  = 0;
  int       quiet_cycles = 0;
  int       burst_left   = 0;
  int       stall_left   = 0;
  stall_mode_t stall_mode = STALL_NONE;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int next_slot(int i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int prev_slot(int i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic deq_rsp_t apply_request(deq_req_t r);
    deq_rsp_t o;
    o.read_value = NO_VALUE;
    o.status     = ST_OK;
    case (r.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (held == DEPTH) begin
          o.status = ST_FULL;
        end else if (r.opcode == OP_PUSH_FRONT) begin
          head_slot = prev_slot(head_slot);
          shadow_slots[head_slot] = r.push_value;
          held++;
        end else begin
          shadow_slots[tail_slot] = r.push_value;
          tail_slot = next_slot(tail_slot);
          held++;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (held == 0) begin
          o.status = ST_EMPTY;
        end else begin
          case (r.opcode)
            OP_POP_FRONT: begin
              o.read_value = shadow_slots[head_slot];
              head_slot = next_slot(head_slot);
              held--;
            end
            OP_POP_REAR: begin
              tail_slot = prev_slot(tail_slot);
              o.read_value = shadow_slots[tail_slot];
              held--;
            end
            OP_PEEK_FRONT: o.read_value = shadow_slots[head_slot];
            default:       o.read_value = shadow_slots[prev_slot(tail_slot)];
          endcase
        end
      end
      default: ;
    endcase
    o.element_count = held[COUNT_W-1:0];
    o.is_empty      = (held == 0);
    return o;
  endfunction

  // predict on request words, check response words
  always @(posedge clk) begin : scoreboard
    deq_rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pending_rsp.push_back(apply_request(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("unexpected response word: value %0d status %0d count %0d empty %0b",
                     rsp.read_value, rsp.status, rsp.element_count, rsp.is_empty);
          end
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
              rsp.element_count !== want.element_count || rsp.is_empty !== want.is_empty) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
              $display("response mismatch at %0t: expected value %0d status %0d count %0d empty %0b",
                       $time, want.read_value, want.status, want.element_count, want.is_empty);
              $display("                          actual   value %0d status %0d count %0d empty %0b",
                       rsp.read_value, rsp.status, rsp.element_count, rsp.is_empty);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // response-side backpressure
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(4, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:   rsp_stall <= 1'b0;
      STALL_SPOTTY: rsp_stall <= ($urandom_range(0, 2) == 0);
      default:      rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_word(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] value);
    int       gap;
    deq_req_t word;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    word.opcode     = op;
    word.push_value = value;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= word;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_word(OP_POP_FRONT, $urandom());
    send_word(OP_POP_REAR, $urandom());
    send_word(OP_PEEK_FRONT, $urandom());
    send_word(OP_PEEK_REAR, $urandom());
    send_word(OP_UNUSED_7, $urandom());
  endtask

  task automatic test_full_queue();
    logic signed [WORD_W-1:0] corner_words [DEPTH] = '{
      32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
      32'sh00000001, 32'shFFFFFFFE, 32'sh55555555, 32'shAAAAAAAA,
      32'sh7FFFFFFE, 32'sh80000001, 32'sh0F0F0F0F, 32'shF0F0F0F0,
      32'sh00FF00FF, 32'shFF00FF00, 32'sh12345678, 32'sh87654321
    };
    for (int i = 0; i < DEPTH; i++) begin
      send_word(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, corner_words[i]);
    end
    send_word(OP_PUSH_FRONT, 32'sh7FFFFFFF);
    send_word(OP_PUSH_REAR, 32'sh80000000);
    send_word(OP_PEEK_FRONT, $urandom());
    send_word(OP_PEEK_REAR, $urandom());
    send_word(OP_UNUSED_6, $urandom());
  endtask

  task automatic test_random_traffic(int words);
    int                       sent;
    int                       phase_left;
    int                       push_pct;
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
    sent       = 0;
    phase_left = 0;
    push_pct   = 50;
    while (sent < words) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 90;
          1:       push_pct = 10;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 39) == 0) begin
        op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
      end else if ($urandom_range(1, 100) <= push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_POP_FRONT;
          1:       op = OP_POP_REAR;
          2:       op = OP_PEEK_FRONT;
          default: op = OP_PEEK_REAR;
        endcase
      end
      case ($urandom_range(0, 7))
        0:       value = 32'sh7FFFFFFF;
        1:       value = 32'sh80000000;
        2:       value = 32'sh00000000;
        3:       value = 32'shFFFFFFFF;
        default: value = $urandom();
      endcase
      send_word(op, value);
      if (op != OP_UNUSED_6 && op != OP_UNUSED_7) begin
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_full_queue();
    test_random_traffic(RANDOM_WORDS);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue.sv
bench/tb_double_ended_queue.sv
